[sv/sv39_page_table_walker_defines.svh]
// Assertion macros for the Sv39 page table walker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SV39PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SV39PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sv39ptw_pkg.sv]
// Shared constants and types of the Sv39 page table walker.
// No dependencies.
`default_nettype none

package sv39ptw_pkg;

  localparam int unsigned XlenBits = 64;
  localparam int unsigned VaBits   = 39;
  localparam int unsigned PpnBits  = 44;
  localparam int unsigned VpnBits  = 9;
  localparam int unsigned OffBits  = 12;
  localparam int unsigned PpnLsb   = 10;

  localparam logic [3:0] MODE_BARE = 4'd0;
  localparam logic [3:0] MODE_SV39 = 4'd8;

  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_PTE       = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ROOT = 1'b1;

  localparam logic [1:0] LEVEL_TOP = 2'd2;
  localparam logic [1:0] LEVEL_MID = 2'd1;
  localparam logic [1:0] LEVEL_LOW = 2'd0;

  typedef struct packed {
    logic                result_kind;
    logic [XlenBits-1:0] walk_addr;
    logic [XlenBits-1:0] phys_addr;
    logic                page_fault;
  } result_t;

endpackage

`default_nettype wire

[sv/sv39ptw_intf.sv]
// Request and result channels of the Sv39 page table walker.
// Depends on sv39ptw_pkg.
`default_nettype none

interface sv39ptw_req_if
  import sv39ptw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                action;
  logic [XlenBits-1:0] vaddr;
  logic [XlenBits-1:0] pte_data;

  modport source (output valid, action, vaddr, pte_data, input ready);
  modport sink   (input valid, action, vaddr, pte_data, output ready);
endinterface

interface sv39ptw_rsp_if
  import sv39ptw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [XlenBits-1:0] walk_addr;
  logic [XlenBits-1:0] phys_addr;
  logic                page_fault;

  modport source (output valid, result_kind, walk_addr, phys_addr, page_fault, input ready);
  modport sink   (input valid, result_kind, walk_addr, phys_addr, page_fault, output ready);
endinterface

`default_nettype wire

[sv/sv39_page_table_walker.sv]
// Sv39 page table walker, top level.
// Result: an accepted request that yields a result has it registered in the output register.
// Throughput: one request per cycle; a held result stalls intake only when not taken.
// Reset: idle, no result pending, mode bare, root table address zero.
// Depends on sv39ptw_pkg, sv39ptw_intf and sv39_page_table_walker_defines.svh.
`default_nettype none
`include "sv39_page_table_walker_defines.svh"

module sv39_page_table_walker
  import sv39ptw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  sv39ptw_req_if.sink              req_i,
  sv39ptw_rsp_if.source            rsp_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [XlenBits-1:0] pwdata,
  output logic      [XlenBits-1:0] prdata,
  output logic                     pready
);

  logic [3:0]          mode_q;
  logic [XlenBits-1:0] root_q;
  logic                busy_q, busy_d;
  logic [1:0]          level_q, level_d;
  logic [VaBits-1:0]   vaddr_q, vaddr_d;
  logic                out_valid_q;
  result_t             out_q, res_d;
  logic                res_valid_d;
  logic                in_acc, out_acc, cfg_wr;

  logic                pte_v, pte_r, pte_w, pte_x;
  logic [PpnBits-1:0]  ppn;
  logic [VpnBits-1:0]  leaf_p0, leaf_p1, next_vpn;
  logic [VpnBits-1:0]  vpn0, vpn1, vpn2_req;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[3] == REG_ROOT) begin
      prdata = root_q;
    end else begin
      prdata = {{(XlenBits-4){1'b0}}, mode_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BARE;
      root_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_ROOT) begin
        root_q <= pwdata;
      end else begin
        mode_q <= pwdata[3:0];
      end
    end
  end

  assign in_acc      = req_i.valid & req_i.ready;
  assign out_acc     = rsp_o.valid & rsp_o.ready;
  assign req_i.ready = ~out_valid_q | rsp_o.ready;

  assign pte_v    = req_i.pte_data[0];
  assign pte_r    = req_i.pte_data[1];
  assign pte_w    = req_i.pte_data[2];
  assign pte_x    = req_i.pte_data[3];
  assign ppn      = req_i.pte_data[PpnLsb +: PpnBits];
  assign vpn0     = vaddr_q[OffBits +: VpnBits];
  assign vpn1     = vaddr_q[OffBits+VpnBits +: VpnBits];
  assign vpn2_req = req_i.vaddr[OffBits+2*VpnBits +: VpnBits];
  assign leaf_p0  = (level_q != LEVEL_LOW) ? vpn0 : ppn[VpnBits-1:0];
  assign leaf_p1  = (level_q == LEVEL_TOP) ? vpn1 : ppn[2*VpnBits-1:VpnBits];
  assign next_vpn = (level_q == LEVEL_TOP) ? vpn1 : vpn0;

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    vaddr_d     = vaddr_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    if (req_i.action == ACT_TRANSLATE) begin
      busy_d            = 1'b0;
      res_valid_d       = 1'b1;
      res_d.result_kind = KIND_DONE;
      if (mode_q == MODE_BARE) begin
        res_d.phys_addr = req_i.vaddr;
      end else if (mode_q != MODE_SV39) begin
        res_d.page_fault = 1'b1;
      end else begin
        busy_d            = 1'b1;
        level_d           = LEVEL_TOP;
        vaddr_d           = req_i.vaddr[VaBits-1:0];
        res_d.result_kind = KIND_READ;
        res_d.walk_addr   = root_q + {{(XlenBits-VpnBits-3){1'b0}}, vpn2_req, 3'b000};
      end
    end else if (busy_q) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = KIND_DONE;
      if (!pte_v || (!pte_r && pte_w)) begin
        busy_d           = 1'b0;
        res_d.page_fault = 1'b1;
      end else if (pte_r || pte_x) begin
        busy_d          = 1'b0;
        res_d.phys_addr = {{(XlenBits-PpnBits-OffBits){1'b0}},
                           ppn[PpnBits-1:2*VpnBits], leaf_p1, leaf_p0,
                           vaddr_q[OffBits-1:0]};
      end else if (level_q == LEVEL_LOW) begin
        busy_d           = 1'b0;
        res_d.page_fault = 1'b1;
      end else begin
        level_d           = level_q - 2'd1;
        res_d.result_kind = KIND_READ;
        res_d.walk_addr   = {{(XlenBits-PpnBits-OffBits){1'b0}}, ppn, next_vpn, 3'b000};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= LEVEL_LOW;
      vaddr_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (in_acc) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        vaddr_q <= vaddr_d;
      end
      if (in_acc && res_valid_d) begin
        out_valid_q <= 1'b1;
        out_q       <= res_d;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_kind = out_q.result_kind;
  assign rsp_o.walk_addr   = out_q.walk_addr;
  assign rsp_o.phys_addr   = out_q.phys_addr;
  assign rsp_o.page_fault  = out_q.page_fault;

  `SV39PTW_ASSERT(a_level_range, !busy_q || level_q != 2'd3, "walk level out of range")
  `SV39PTW_ASSERT(a_stall_blocks, !(out_valid_q && !rsp_o.ready) || !req_i.ready, "intake while result held")
  `SV39PTW_ASSERT_NEXT(a_read_busy, in_acc && res_valid_d && res_d.result_kind == KIND_READ, busy_q && out_valid_q, "read issued without active walk")
  `SV39PTW_ASSERT_NEXT(a_done_idle, in_acc && res_valid_d && res_d.result_kind == KIND_DONE, !busy_q && out_valid_q, "walk still active after finish")
  `SV39PTW_ASSERT(a_fault_zero, !(out_valid_q && out_q.page_fault) || out_q.phys_addr == '0, "fault with nonzero address")

endmodule

`default_nettype wire

[tb/sv39_page_table_walker_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Sv39 page table walker: drives requests and PTE data,
// predicts each translation step and checks every result in order.
// Depends on sv39ptw_pkg, sv39ptw_intf and the walker RTL.

module sv39_page_table_walker_test;
  import sv39ptw_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [XlenBits-1:0] ALL_ONES = {XlenBits{1'b1}};
  localparam logic [3:0] MODE_FAULT_MAX = 4'hF;
  localparam logic [3:0] PTE_POINTER    = 4'b0001;
  localparam logic [3:0] PTE_READ_LEAF  = 4'b0011;
  localparam logic [3:0] PTE_EXEC_LEAF  = 4'b1001;
  localparam logic [3:0] PTE_WRITE_ONLY = 4'b0101;

  typedef struct packed {
    logic                action;
    logic [XlenBits-1:0] vaddr;
    logic [XlenBits-1:0] pte_data;
  } walk_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [XlenBits-1:0] pwdata;
  logic [XlenBits-1:0] prdata;
  logic                pready;

  sv39ptw_req_if req_if ();
  sv39ptw_rsp_if rsp_if ();

  sv39_page_table_walker i_dut (
    .clk_i,
    .rst_ni,
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5ns clk_i = ~clk_i;

  walk_req_t pending_requests[$];
  result_t   expected_results[$];
  walk_req_t cur_req;
  result_t   pred;
  result_t   want;

  logic [3:0]          mode_reg;
  logic [XlenBits-1:0] root_reg;
  bit                  walking;
  logic [1:0]          walk_lvl;
  logic [VaBits-1:0]   walk_va;

  int send_idle_pct;
  int recv_stall_pct;
  int n_pushed;
  int n_accepted;
  int n_results;
  int n_reads;
  int n_faults;
  int n_writes;
  int n_errors;
  int unsigned cycle_cnt;

  function automatic logic [XlenBits-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VpnBits-1:0] vpn(input logic [VaBits-1:0] va, input logic [1:0] lvl);
    return va[OffBits + VpnBits * int'(lvl) +: VpnBits];
  endfunction

  function automatic logic [XlenBits-1:0] ptr_pte();
    logic [XlenBits-1:0] pte;
    pte = rand64();
    pte[3:0] = PTE_POINTER;
    return pte;
  endfunction

  function automatic logic [XlenBits-1:0] make_leaf_entry();
    logic [XlenBits-1:0] pte;
    logic [2:0]          xwr;
    pte = rand64();
    do xwr = 3'($urandom_range(7, 1)); while (xwr[1] && !xwr[0]);
    pte[3:0] = {xwr, 1'b1};
    return pte;
  endfunction

  function automatic logic [XlenBits-1:0] bad_pte();
    logic [XlenBits-1:0] pte;
    pte = rand64();
    if ($urandom_range(1, 0) == 0) pte[0] = 1'b0;
    else pte[2:0] = PTE_WRITE_ONLY[2:0];
    return pte;
  endfunction

  // One accepted request or PTE; returns 1 when it produces a result.
  function automatic bit translate_step(input walk_req_t it, output result_t res);
    logic [PpnBits-1:0] ppn;
    logic [PpnBits-1:0] leaf;
    res = '0;
    res.result_kind = KIND_DONE;
    if (it.action == ACT_TRANSLATE) begin
      walking = 1'b0;
      if (mode_reg == MODE_BARE) begin
        res.phys_addr = it.vaddr;
        return 1'b1;
      end
      if (mode_reg != MODE_SV39) begin
        res.page_fault = 1'b1;
        return 1'b1;
      end
      walk_va = it.vaddr[VaBits-1:0];
      walk_lvl = LEVEL_TOP;
      walking = 1'b1;
      res.result_kind = KIND_READ;
      res.walk_addr = root_reg + {52'b0, vpn(walk_va, LEVEL_TOP), 3'b000};
      return 1'b1;
    end
    if (!walking) return 1'b0;
    ppn = it.pte_data[PpnLsb +: PpnBits];
    if (!it.pte_data[0] || (!it.pte_data[1] && it.pte_data[2])) begin
      walking = 1'b0;
      res.page_fault = 1'b1;
      return 1'b1;
    end
    if (it.pte_data[1] || it.pte_data[3]) begin
      leaf = ppn;
      if (walk_lvl != LEVEL_LOW) leaf[8:0] = vpn(walk_va, LEVEL_LOW);
      if (walk_lvl == LEVEL_TOP) leaf[17:9] = vpn(walk_va, LEVEL_MID);
      res.phys_addr = {8'b0, leaf, walk_va[OffBits-1:0]};
      walking = 1'b0;
      return 1'b1;
    end
    if (walk_lvl == LEVEL_LOW) begin
      walking = 1'b0;
      res.page_fault = 1'b1;
      return 1'b1;
    end
    walk_lvl = walk_lvl - 2'd1;
    res.result_kind = KIND_READ;
    res.walk_addr = {8'b0, ppn, 12'b0} + {52'b0, vpn(walk_va, walk_lvl), 3'b000};
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [XlenBits-1:0] got,
                                 input logic [XlenBits-1:0] exp_val);
    n_errors++;
    if (n_errors <= 20)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, exp_val);
  endtask

  task automatic push_req(input logic action, input logic [XlenBits-1:0] va,
                          input logic [XlenBits-1:0] pte);
    walk_req_t it;
    it.action = action;
    it.vaddr = va;
    it.pte_data = pte;
    pending_requests.push_back(it);
    n_pushed++;
  endtask

  // Translate, then zero to three pointers, then a leaf or a bad PTE; sometimes cut short.
  task automatic push_walk();
    int n_ptr;
    int r;
    n_ptr = $urandom_range(3, 0);
    r = $urandom_range(99, 0);
    push_req(ACT_TRANSLATE, rand64(), rand64());
    for (int i = 0; i < n_ptr; i++) push_req(ACT_PTE, rand64(), ptr_pte());
    if (n_ptr < 3 && r >= 10)
      push_req(ACT_PTE, rand64(), (r < 30) ? bad_pte() : make_leaf_entry());
  endtask

  task automatic push_random(input int count);
    int start;
    start = n_pushed;
    while (n_pushed - start < count) begin
      if (mode_reg != MODE_SV39)
        push_req(($urandom_range(99, 0) < 80) ? ACT_TRANSLATE : ACT_PTE, rand64(), rand64());
      else if ($urandom_range(99, 0) < 6)
        push_req(ACT_PTE, rand64(), rand64());
      else
        push_walk();
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (n_accepted != n_pushed || expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [XlenBits-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {1'b0, idx, 2'b00} << 1;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODE) mode_reg = value[3:0];
    else root_reg = value;
    n_writes++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (translate_step(cur_req, pred)) expected_results.push_back(pred);
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_req = pending_requests.pop_front();
          req_if.valid    <= 1'b1;
          req_if.action   <= cur_req.action;
          req_if.vaddr    <= cur_req.vaddr;
          req_if.pte_data <= cur_req.pte_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.phys_addr, '0);
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (want.result_kind == KIND_READ) n_reads++;
          if (want.page_fault) n_faults++;
          if (rsp_if.result_kind !== want.result_kind)
            report_mismatch("result_kind", rsp_if.result_kind, want.result_kind);
          if (rsp_if.walk_addr !== want.walk_addr)
            report_mismatch("walk_addr", rsp_if.walk_addr, want.walk_addr);
          if (rsp_if.phys_addr !== want.phys_addr)
            report_mismatch("phys_addr", rsp_if.phys_addr, want.phys_addr);
          if (rsp_if.page_fault !== want.page_fault)
            report_mismatch("page_fault", rsp_if.page_fault, want.page_fault);
        end
      end
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("sv39_page_table_walker_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [XlenBits-1:0] value;
    logic [3:0]          m;
    req_if.valid = 1'b0;
    req_if.action = ACT_TRANSLATE;
    req_if.vaddr = '0;
    req_if.pte_data = '0;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mode_reg = MODE_BARE;
    root_reg = '0;
    walking = 1'b0;
    walk_lvl = LEVEL_LOW;
    walk_va = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bare mode out of reset: pass-through, PTE data ignored
    push_req(ACT_TRANSLATE, ALL_ONES, ALL_ONES);
    push_req(ACT_TRANSLATE, '0, '0);
    push_req(ACT_PTE, ALL_ONES, ALL_ONES);
    settle();

    write_reg(REG_MODE, {60'b0, MODE_FAULT_MAX});
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), ptr_pte());
    settle();

    // Sv39 with the root at the top of the address space so the first read wraps
    write_reg(REG_MODE, {60'b0, MODE_SV39});
    write_reg(REG_ROOT, ALL_ONES);
    push_req(ACT_PTE, rand64(), make_leaf_entry());
    push_req(ACT_TRANSLATE, ALL_ONES, '0);
    push_req(ACT_PTE, '0, {ALL_ONES[63:4], PTE_POINTER});
    push_req(ACT_PTE, ALL_ONES, {60'b0, PTE_POINTER});
    push_req(ACT_PTE, '0, ALL_ONES);
    push_req(ACT_TRANSLATE, '0, ALL_ONES);
    push_req(ACT_PTE, rand64(), {60'(rand64() >> 4), PTE_READ_LEAF});
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), ptr_pte());
    push_req(ACT_PTE, rand64(), {60'(rand64() >> 4), PTE_EXEC_LEAF});
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), '0);
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), {60'(rand64() >> 4), PTE_WRITE_ONLY});
    push_req(ACT_TRANSLATE, rand64(), rand64());
    repeat (3) push_req(ACT_PTE, rand64(), ptr_pte());
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), ptr_pte());
    push_req(ACT_TRANSLATE, rand64(), rand64());
    push_req(ACT_PTE, rand64(), make_leaf_entry());
    push_req(ACT_PTE, rand64(), ptr_pte());
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      m = MODE_SV39;
      if (p == 2) m = MODE_BARE;
      if (p == 5) do m = 4'($urandom_range(15, 1)); while (m == MODE_SV39);
      value = rand64();
      value[3:0] = m;
      write_reg(REG_MODE, value);
      value = (p == 0) ? '0 : (p == 1) ? ALL_ONES : rand64();
      write_reg(REG_ROOT, value);
      push_random(95);
      // hold off the sender until the walker has drained
      wait_drained();
      push_random(95);
      settle();
    end

    repeat (10) @(posedge clk_i);
    $display("%0d requests accepted over %0d register writes and four idle/stall patterns",
             n_accepted, n_writes);
    $display("%0d results checked: %0d PTE reads, %0d page faults", n_results, n_reads,
             n_faults);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("sv39_page_table_walker_test: PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("sv39_page_table_walker_test: FAIL");
    end
    $finish;
  end

endmodule
